FILE: hdl/ccts_pkg.sv
// Shared types, codes and a helper function of the credit counter task scheduler.
`default_nettype none

package ccts_pkg;

    // Operation carried by a request beat.
    typedef enum logic [1:0] {
        MODE_ENQUEUE = 2'd0,
        MODE_DEQUEUE = 2'd1,
        MODE_TICK    = 2'd2,
        MODE_PICK    = 2'd3
    } mode_e;

    // Completion code carried by a response beat.
    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_FULL       = 2'd1,
        STAT_NOT_QUEUED = 2'd2,
        STAT_DUPLICATE  = 2'd3
    } status_e;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LAUNCH,
        ST_SWEEP,
        ST_REFILL,
        ST_REPLY
    } state_e;

    // Command broadcast to every cell of the queue.
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_ENQUEUE,
        CELL_SHIFT,
        CELL_TICK,
        CELL_REFILL
    } cell_op_e;

    typedef struct packed {
        mode_e      mode;
        logic [3:0] task_id;
        logic [6:0] task_priority;
        logic [7:0] start_credit;
    } req_t;

    typedef struct packed {
        logic [3:0] picked_id;
        logic       picked_valid;
        logic       resched_req;
        logic [7:0] remaining_credit;
        logic [4:0] queued_tasks;
        status_e    status;
    } rsp_t;

    // Contents of one queue entry.
    typedef struct packed {
        logic [3:0] task_id;
        logic [7:0] credit;
        logic [6:0] priority_val;
    } slot_t;

    typedef struct packed {
        cell_op_e   op;
        logic [3:0] task_id;
        logic [6:0] priority_val;
        logic [7:0] credit;
        logic [6:0] base_slice;
    } cell_cmd_t;

    // Running best candidate that travels down the chain during a pick.
    typedef struct packed {
        logic       live;
        logic       found;
        logic [3:0] task_id;
        logic [7:0] credit;
    } token_t;

    // Credit after one tick: decrement, clamping at zero.
    function automatic logic [7:0] tick_credit(input logic [7:0] credit);
        logic [7:0] result;
        begin
            if (credit <= 8'd1)
            begin
                result = 8'd0;
            end
            else
            begin
                result = credit - 8'd1;
            end
            return result;
        end
    endfunction

endpackage

`default_nettype wire

FILE: hdl/ccts_cell.sv
// One queue entry of the scheduler chain, with its share of the pick sweep.
`default_nettype none

module ccts_cell #(
    parameter int INDEX = 0,
    parameter int LEN_W = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ccts_pkg::cell_cmd_t cmd,
    input  logic [LEN_W-1:0]    queue_len,
    input  ccts_pkg::slot_t     neighbor,
    input  logic                shift_in,
    output logic                shift_out,
    input  ccts_pkg::token_t    tok_in,
    output ccts_pkg::token_t    tok_out,
    output ccts_pkg::slot_t     slot,
    output logic [7:0]          hit_credit
);
    import ccts_pkg::*;

    slot_t      slot_reg;
    slot_t      slot_next;
    token_t     tok_reg;
    token_t     tok_next;
    logic       occupied;
    logic       at_tail;
    logic       hit;
    logic       take_own;

    // Position of this entry relative to the queue length.
    assign occupied = LEN_W'(INDEX) < queue_len;
    assign at_tail  = LEN_W'(INDEX) == queue_len;
    assign hit      = occupied && (slot_reg.task_id == cmd.task_id);

    // Once a match is seen, every entry from it to the tail moves up by one.
    assign shift_out  = shift_in | hit;
    assign hit_credit = hit ? slot_reg.credit : 8'd0;
    assign slot       = slot_reg;

    // Entry update for the broadcast command.
    always_comb
    begin
        slot_next = slot_reg;
        case (cmd.op)
            CELL_ENQUEUE:
            begin
                if (at_tail)
                begin
                    slot_next.task_id      = cmd.task_id;
                    slot_next.credit       = cmd.credit;
                    slot_next.priority_val = cmd.priority_val;
                end
            end
            CELL_SHIFT:
            begin
                if (shift_out)
                begin
                    slot_next = neighbor;
                end
            end
            CELL_TICK:
            begin
                if (hit)
                begin
                    slot_next.credit = tick_credit(slot_reg.credit);
                end
            end
            CELL_REFILL:
            begin
                slot_next.credit = {1'b0, cmd.base_slice} + {1'b0, slot_reg.priority_val};
            end
            default:
            begin
                slot_next = slot_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    // Strictly larger credit replaces the candidate, so the head wins a tie.
    assign take_own = occupied && (!tok_in.found || (slot_reg.credit > tok_in.credit));

    always_comb
    begin
        tok_next = tok_in;
        if (take_own)
        begin
            tok_next.found   = 1'b1;
            tok_next.task_id = slot_reg.task_id;
            tok_next.credit  = slot_reg.credit;
        end
    end

    // The live flag marks the sweep pulse; the rest is payload.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

FILE: hdl/credit_counter_task_scheduler_core.sv
// Credit counter task scheduler: ready queue held in a chain of cells.
//
// Requests arrive as beats on req (valid/ready) and each one gives exactly
// one response beat on rsp (valid/ready). The base slice register must be
// written through cfg_wen/cfg_wdata only while the block is idle, which the
// block itself does not enforce; it resets to 10. Requests are handled one
// at a time: req_ready is high only in the idle state, but a finished
// response waits in its own output register, so the next request is taken
// while the previous response is still unread. Enqueue, dequeue and tick:
// the request beat is registered and executed in the exec state, which
// loads the response register and returns to idle; a new request is not
// taken until then. Pick: a candidate token walks the chain one cell a
// cycle from the launch state and the winner is registered for the reply
// state; when every credit is zero the credits are refilled once and the
// walk runs again. An empty queue answers a pick from the exec state.
// If the receiver stalls, the block holds its finished result; until the
// response register is free only a pick's sweep and refill change the queue.
// Reset empties the queue; entry contents are not cleared.
`default_nettype none

module credit_counter_task_scheduler_core #(
    parameter int MAX_TASKS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  ccts_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output ccts_pkg::rsp_t rsp,
    input  logic           cfg_wen,
    input  logic [6:0]     cfg_wdata
);
    import ccts_pkg::*;

    localparam int LEN_W = $clog2(MAX_TASKS + 1);
    localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_TASKS);

    state_e            state_reg;
    state_e            state_next;
    req_t              op_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [LEN_W-1:0]  len_next;
    logic [6:0]        base_slice_reg;
    logic              refilled_reg;
    logic              rsp_valid_reg;
    rsp_t              rsp_reg;
    rsp_t              rsp_next;
    logic              rsp_load;
    logic [3:0]        best_id_reg;
    logic [7:0]        best_credit_reg;
    logic              best_load;
    logic              launch;
    logic              out_free;
    logic              found;
    logic              redo_pick;
    logic [7:0]        hit_or;
    cell_cmd_t         cmd;
    token_t            tok_first;
    slot_t             cell_slot [MAX_TASKS];
    token_t            cell_tok [MAX_TASKS];
    logic [7:0]        cell_hit [MAX_TASKS];
    logic [MAX_TASKS-1:0] shift_chain;

    assign out_free = !rsp_valid_reg || rsp_ready;

    // Chain of queue cells; data shifts toward the head, the token toward the tail.
    assign tok_first = '{live: launch, found: 1'b0, task_id: 4'd0, credit: 8'd0};

    for (genvar i = 0; i < MAX_TASKS; i++)
    begin : g_cell
        slot_t  nb;
        logic   sh_in;
        token_t tk_in;

        if (i == MAX_TASKS - 1)
        begin : g_last
            assign nb = cell_slot[i];
        end
        else
        begin : g_mid
            assign nb = cell_slot[i + 1];
        end

        if (i == 0)
        begin : g_head
            assign sh_in = 1'b0;
            assign tk_in = tok_first;
        end
        else
        begin : g_rest
            assign sh_in = shift_chain[i - 1];
            assign tk_in = cell_tok[i - 1];
        end

        ccts_cell #(
            .INDEX (i),
            .LEN_W (LEN_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .queue_len  (len_reg),
            .neighbor   (nb),
            .shift_in   (sh_in),
            .shift_out  (shift_chain[i]),
            .tok_in     (tk_in),
            .tok_out    (cell_tok[i]),
            .slot       (cell_slot[i]),
            .hit_credit (cell_hit[i])
        );
    end

    // The match chain's tail tells whether the named task is queued.
    assign found = shift_chain[MAX_TASKS-1];

    // Credit of the matching entry; at most one entry matches.
    always_comb
    begin
        hit_or = 8'd0;
        for (int i = 0; i < MAX_TASKS; i++)
        begin
            hit_or = hit_or | cell_hit[i];
        end
    end

    // A sweep that finds only zero credits triggers one refill and a second sweep.
    assign redo_pick = (cell_tok[MAX_TASKS-1].credit == 8'd0) && !refilled_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if ((op_reg.mode == MODE_PICK) && (len_reg != '0))
                begin
                    state_next = ST_LAUNCH;
                end
                else if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_LAUNCH:
            begin
                state_next = ST_SWEEP;
            end
            ST_SWEEP:
            begin
                if (cell_tok[MAX_TASKS-1].live)
                begin
                    state_next = redo_pick ? ST_REFILL : ST_REPLY;
                end
            end
            ST_REFILL:
            begin
                state_next = ST_LAUNCH;
            end
            ST_REPLY:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs of the controller: cell command, sweep launch and response.
    always_comb
    begin
        req_ready             = 1'b0;
        launch                = 1'b0;
        best_load             = 1'b0;
        rsp_load              = 1'b0;
        len_next              = len_reg;
        cmd.op                = CELL_HOLD;
        cmd.task_id           = op_reg.task_id;
        cmd.priority_val      = op_reg.task_priority;
        cmd.credit            = op_reg.start_credit;
        cmd.base_slice        = base_slice_reg;
        rsp_next              = '0;
        rsp_next.status       = STAT_OK;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
            end
            ST_EXEC:
            begin
                case (op_reg.mode)
                    MODE_ENQUEUE:
                    begin
                        rsp_load = out_free;
                        if (found)
                        begin
                            rsp_next.status = STAT_DUPLICATE;
                        end
                        else if (len_reg == MaxLen)
                        begin
                            rsp_next.status = STAT_FULL;
                        end
                        else
                        begin
                            len_next = len_reg + LEN_W'(1);
                            if (out_free)
                            begin
                                cmd.op = CELL_ENQUEUE;
                            end
                        end
                    end
                    MODE_DEQUEUE:
                    begin
                        rsp_load = out_free;
                        if (!found)
                        begin
                            rsp_next.status = STAT_NOT_QUEUED;
                        end
                        else
                        begin
                            len_next = len_reg - LEN_W'(1);
                            if (out_free)
                            begin
                                cmd.op = CELL_SHIFT;
                            end
                        end
                    end
                    MODE_TICK:
                    begin
                        rsp_load = out_free;
                        if (!found)
                        begin
                            rsp_next.status = STAT_NOT_QUEUED;
                        end
                        else
                        begin
                            rsp_next.resched_req      = (hit_or <= 8'd1);
                            rsp_next.remaining_credit = tick_credit(hit_or);
                            if (out_free)
                            begin
                                cmd.op = CELL_TICK;
                            end
                        end
                    end
                    MODE_PICK:
                    begin
                        rsp_load = out_free && (len_reg == '0);
                    end
                    default:
                    begin
                        rsp_load = 1'b0;
                    end
                endcase
            end
            ST_LAUNCH:
            begin
                launch = 1'b1;
            end
            ST_SWEEP:
            begin
                best_load = cell_tok[MAX_TASKS-1].live && !redo_pick;
            end
            ST_REFILL:
            begin
                cmd.op = CELL_REFILL;
            end
            ST_REPLY:
            begin
                rsp_load                  = out_free;
                rsp_next.picked_id        = best_id_reg;
                rsp_next.picked_valid     = 1'b1;
                rsp_next.remaining_credit = best_credit_reg;
            end
            default:
            begin
                rsp_load = 1'b0;
            end
        endcase
        rsp_next.queued_tasks = 5'(len_next);
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            len_reg        <= '0;
            base_slice_reg <= 7'd10;
            refilled_reg   <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (rsp_load)
            begin
                len_reg <= len_next;
            end
            if (cfg_wen)
            begin
                base_slice_reg <= cfg_wdata;
            end
            if (state_reg == ST_EXEC)
            begin
                refilled_reg <= 1'b0;
            end
            else if (state_reg == ST_REFILL)
            begin
                refilled_reg <= 1'b1;
            end
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: request beat, sweep winner and response beat.
    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            op_reg <= req;
        end
        if (best_load)
        begin
            best_id_reg     <= cell_tok[MAX_TASKS-1].task_id;
            best_credit_reg <= cell_tok[MAX_TASKS-1].credit;
        end
        if (rsp_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire
